[design/lrs_pkg.sv]
package lrs_pkg;

  localparam int TIME_BITS_DEF = 32;

  localparam logic [31:0] CONNECT_TIMEOUT_RST = 32'd15000;
  localparam logic [31:0] INITIAL_BACKOFF_RST = 32'd1000;
  localparam logic [31:0] MAX_BACKOFF_RST     = 32'd60000;

  typedef enum logic [2:0] {
    CFG_WIFI_ENABLED    = 3'd0,
    CFG_SSID_PRESENT    = 3'd1,
    CFG_CONNECT_TIMEOUT = 3'd2,
    CFG_INITIAL_BACKOFF = 3'd3,
    CFG_MAX_BACKOFF     = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    LS_DISCONNECTED = 3'd0,
    LS_DISABLED     = 3'd1,
    LS_CONNECTING   = 3'd2,
    LS_CONNECTED    = 3'd3,
    LS_FAILED       = 3'd4
  } link_state_t;

  typedef enum logic [2:0] {
    RSN_UNKNOWN     = 3'd0,
    RSN_NO_CRED     = 3'd1,
    RSN_AUTH        = 3'd2,
    RSN_NO_AP       = 3'd3,
    RSN_TIMEOUT     = 3'd4,
    RSN_SIGNAL_LOST = 3'd5,
    RSN_MANUAL      = 3'd6
  } reason_t;

  typedef enum logic [2:0] {
    RES_STARTED      = 3'd0,
    RES_ALREADY      = 3'd1,
    RES_CONNECTED    = 3'd2,
    RES_NO_CRED      = 3'd3,
    RES_AUTH         = 3'd4,
    RES_NO_AP        = 3'd5,
    RES_TIMEOUT      = 3'd6,
    RES_ADAPTER_FAIL = 3'd7
  } result_t;

  typedef enum logic [1:0] {
    EV_NONE             = 2'd0,
    EV_CONNECTED        = 2'd1,
    EV_DISCONNECTED     = 2'd2,
    EV_RECONNECT_FAILED = 2'd3
  } event_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        start_ok;
    logic [2:0]  adapter_state;
    logic [2:0]  adapter_reason;
    logic [2:0]  drop_reason;
    logic [2:0]  connect_outcome;
  } lrs_in_t;

  typedef struct packed {
    logic        start_request;
    logic        connect_request;
    logic        disconnect_request;
    logic [1:0]  event_kind;
    logic [2:0]  event_reason;
    logic [2:0]  conn_state;
    logic [2:0]  disconnect_reason;
    logic [2:0]  last_result;
    logic        link_up;
    logic [31:0] next_reconnect_ms;
    logic [31:0] current_backoff_ms;
  } lrs_out_t;

endpackage

[design/link_reconnect_supervisor.sv]
// channel  direction  ports                          payload
// in       input      in_valid / in_ready / in_data  lrs_in_t, one tick
// out      output     out_valid / out_ready / out_data  lrs_out_t, one result per tick
// cfg      input      cfg_we / cfg_index / cfg_wdata   register write, no wait
//
// one tick per cycle unless a result held by out_ready stalls in_ready: the tick is worked out
// in the cycle it is accepted and its result sits in the output register on the next cycle;
// the single state update (compares, one add, a doubling) sets that figure
// a result waiting on out_ready does not block the next tick if it is taken the same cycle
// synchronous active-low reset clears the supervisor state and loads register defaults
module link_reconnect_supervisor #(
  parameter int TIME_BITS = lrs_pkg::TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lrs_pkg::lrs_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lrs_pkg::lrs_out_t out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_wdata
);
  import lrs_pkg::*;

  // bits of now_ms that count, and width for mixed-width compares
  localparam int NW = (TIME_BITS < 32) ? TIME_BITS : 32;
  localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

  // configuration
  logic        enabled_r;
  logic        ssid_r;
  logic [31:0] timeout_r;
  logic [31:0] init_bo_r;
  logic [31:0] max_bo_r;

  // supervisor state
  logic                 started_r, started_nxt;
  logic                 link_r, link_nxt;
  logic                 attempt_r, attempt_nxt;
  logic [TIME_BITS-1:0] start_time_r, start_time_nxt;
  logic [TIME_BITS-1:0] reconnect_r, reconnect_nxt;
  logic [31:0]          pending_r, pending_nxt;
  logic [31:0]          next_bo_r, next_bo_nxt;
  logic [2:0]           status_r, status_nxt;
  logic [2:0]           reason_r, reason_nxt;
  logic [2:0]           result_r, result_nxt;

  logic     out_valid_r;
  lrs_out_t out_r, out_nxt;
  logic     accept;

  function automatic logic [2:0] clean_reason(input logic [2:0] r);
    return (r > RSN_MANUAL) ? RSN_UNKNOWN : r;
  endfunction

  function automatic logic [2:0] result_for_reason(input logic [2:0] r);
    case (r)
      RSN_NO_CRED: return RES_NO_CRED;
      RSN_AUTH:    return RES_AUTH;
      RSN_NO_AP:   return RES_NO_AP;
      RSN_TIMEOUT: return RES_TIMEOUT;
      default:     return RES_ADAPTER_FAIL;
    endcase
  endfunction

  function automatic logic [2:0] reason_for_result(input logic [2:0] res);
    case (res)
      RES_NO_CRED: return RSN_NO_CRED;
      RES_AUTH:    return RSN_AUTH;
      RES_NO_AP:   return RSN_NO_AP;
      RES_TIMEOUT: return RSN_TIMEOUT;
      default:     return RSN_UNKNOWN;
    endcase
  endfunction

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // tick decode
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] age;
  logic [2:0]           a_state;
  logic [2:0]           a_reason;
  logic [2:0]           d_reason;
  logic [2:0]           outcome;
  logic                 timed_out;
  logic                 due;

  // schedule values from the current delay
  logic [TIME_BITS-1:0] sched_time;
  logic [32:0]          dbl;
  logic [31:0]          sched_bo;

  assign now_t     = TIME_BITS'(in_data.now_ms[NW-1:0]);
  assign age       = now_t - start_time_r;
  assign a_state   = (in_data.adapter_state > LS_FAILED) ? LS_FAILED : in_data.adapter_state;
  assign a_reason  = clean_reason(in_data.adapter_reason);
  assign d_reason  = clean_reason(in_data.drop_reason);
  assign outcome   = in_data.connect_outcome;
  assign timed_out = CW'(age) >= CW'(timeout_r);
  assign due       = (reconnect_r == '0) || (now_t >= reconnect_r);

  assign sched_time = now_t + TIME_BITS'(next_bo_r);
  assign dbl        = {next_bo_r, 1'b0};
  always_comb begin
    if (next_bo_r < max_bo_r) begin
      sched_bo = (dbl > {1'b0, max_bo_r}) ? max_bo_r : dbl[31:0];
    end else begin
      sched_bo = next_bo_r;
    end
  end

  logic       start_req, conn_req, disc_req;
  logic [1:0] ev_kind;
  logic [2:0] ev_reason;
  logic       do_fail, do_conn, do_sched;
  logic [2:0] fail_res, fail_rsn, conn_rsn;

  always_comb begin
    started_nxt    = started_r;
    link_nxt       = link_r;
    attempt_nxt    = attempt_r;
    start_time_nxt = start_time_r;
    reconnect_nxt  = reconnect_r;
    pending_nxt    = pending_r;
    next_bo_nxt    = next_bo_r;
    status_nxt     = status_r;
    reason_nxt     = reason_r;
    result_nxt     = result_r;
    start_req      = 1'b0;
    conn_req       = 1'b0;
    disc_req       = 1'b0;
    ev_kind        = EV_NONE;
    ev_reason      = RSN_UNKNOWN;
    do_fail        = 1'b0;
    do_conn        = 1'b0;
    do_sched       = 1'b0;
    fail_res       = RES_ADAPTER_FAIL;
    fail_rsn       = RSN_UNKNOWN;
    conn_rsn       = a_reason;

    if (!started_r) begin
      start_req   = 1'b1;
      started_nxt = in_data.start_ok;
    end

    if (!started_r && !in_data.start_ok) begin
      do_fail  = 1'b1;
      fail_res = RES_ADAPTER_FAIL;
      fail_rsn = RSN_UNKNOWN;
    end else if (!(enabled_r && ssid_r)) begin
      result_nxt    = RES_NO_CRED;
      attempt_nxt   = 1'b0;
      reconnect_nxt = '0;
      pending_nxt   = '0;
      next_bo_nxt   = init_bo_r;
      status_nxt    = LS_DISABLED;
      reason_nxt    = RSN_NO_CRED;
      if (link_r) begin
        disc_req  = 1'b1;
        ev_kind   = EV_DISCONNECTED;
        ev_reason = RSN_NO_CRED;
      end
      link_nxt = 1'b0;
    end else begin
      status_nxt = a_state;
      reason_nxt = a_reason;
      if (a_state == LS_CONNECTED) begin
        do_conn = 1'b1;
      end else if (link_r) begin
        // established link dropped
        link_nxt    = 1'b0;
        attempt_nxt = 1'b0;
        status_nxt  = LS_DISCONNECTED;
        reason_nxt  = d_reason;
        result_nxt  = result_for_reason(d_reason);
        ev_kind     = EV_DISCONNECTED;
        ev_reason   = d_reason;
        do_sched    = 1'b1;
      end else if (attempt_r) begin
        if (timed_out) begin
          do_fail  = 1'b1;
          fail_res = RES_TIMEOUT;
          fail_rsn = RSN_TIMEOUT;
        end
      end else if (due) begin
        conn_req       = 1'b1;
        start_time_nxt = now_t;
        attempt_nxt    = 1'b1;
        status_nxt     = LS_CONNECTING;
        reason_nxt     = RSN_UNKNOWN;
        result_nxt     = outcome;
        if (outcome == RES_CONNECTED || outcome == RES_ALREADY) begin
          do_conn = 1'b1;
        end else if (outcome != RES_STARTED) begin
          do_fail  = 1'b1;
          fail_res = outcome;
          fail_rsn = reason_for_result(outcome);
        end
      end
    end

    if (do_conn) begin
      status_nxt    = LS_CONNECTED;
      reason_nxt    = conn_rsn;
      result_nxt    = RES_CONNECTED;
      attempt_nxt   = 1'b0;
      reconnect_nxt = '0;
      pending_nxt   = '0;
      next_bo_nxt   = init_bo_r;
      if (!link_r) begin
        ev_kind   = EV_CONNECTED;
        ev_reason = RSN_UNKNOWN;
      end
      link_nxt = 1'b1;
    end

    if (do_fail) begin
      link_nxt    = 1'b0;
      attempt_nxt = 1'b0;
      result_nxt  = fail_res;
      status_nxt  = LS_FAILED;
      reason_nxt  = fail_rsn;
      ev_kind     = EV_RECONNECT_FAILED;
      ev_reason   = fail_rsn;
      // missing credential answer schedules nothing
      if (fail_res != RES_NO_CRED) begin
        do_sched = 1'b1;
      end
    end

    if (do_sched) begin
      pending_nxt   = next_bo_r;
      reconnect_nxt = sched_time;
      next_bo_nxt   = sched_bo;
    end

    out_nxt.start_request      = start_req;
    out_nxt.connect_request    = conn_req;
    out_nxt.disconnect_request = disc_req;
    out_nxt.event_kind         = ev_kind;
    out_nxt.event_reason       = ev_reason;
    out_nxt.conn_state         = status_nxt;
    out_nxt.disconnect_reason  = reason_nxt;
    out_nxt.last_result        = result_nxt;
    out_nxt.link_up            = link_nxt;
    out_nxt.next_reconnect_ms  = 32'(CW'(reconnect_nxt));
    out_nxt.current_backoff_ms = pending_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      ssid_r    <= 1'b0;
      timeout_r <= CONNECT_TIMEOUT_RST;
      init_bo_r <= INITIAL_BACKOFF_RST;
      max_bo_r  <= MAX_BACKOFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIFI_ENABLED:    enabled_r <= cfg_wdata[0];
        CFG_SSID_PRESENT:    ssid_r    <= cfg_wdata[0];
        CFG_CONNECT_TIMEOUT: timeout_r <= cfg_wdata;
        CFG_INITIAL_BACKOFF: init_bo_r <= cfg_wdata;
        CFG_MAX_BACKOFF:     max_bo_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r    <= 1'b0;
      link_r       <= 1'b0;
      attempt_r    <= 1'b0;
      start_time_r <= '0;
      reconnect_r  <= '0;
      pending_r    <= '0;
      next_bo_r    <= INITIAL_BACKOFF_RST;
      status_r     <= LS_DISCONNECTED;
      reason_r     <= RSN_UNKNOWN;
      result_r     <= RES_STARTED;
    end else if (accept) begin
      started_r    <= started_nxt;
      link_r       <= link_nxt;
      attempt_r    <= attempt_nxt;
      start_time_r <= start_time_nxt;
      reconnect_r  <= reconnect_nxt;
      pending_r    <= pending_nxt;
      next_bo_r    <= next_bo_nxt;
      status_r     <= status_nxt;
      reason_r     <= reason_nxt;
      result_r     <= result_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

endmodule
